// ===== design/midi_transpose_stops_layer_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MIDI_TRANSPOSE_STOPS_LAYER_CORE_DEFINES_SVH
`define MIDI_TRANSPOSE_STOPS_LAYER_CORE_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define MTSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtsl assertion failed");

// Clocked assertion that also holds through reset.
`define MTSL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mtsl assertion failed");

`endif

// ===== design/mtsl_pkg.sv =====
// Package: widths, codes and helpers for the transpose / stops layer block.
`timescale 1ns / 1ps
package mtsl_pkg;

  localparam int TRANSPOSE_LIMIT = 12;
  localparam int STOP_COUNT      = 4;
  localparam int STOP_SPACING    = 12;

  localparam int KIND_W    = 3;
  localparam int OKIND_W   = 2;
  localparam int CHAN_W    = 4;
  localparam int KEY_W     = 7;
  localparam int AMT_W     = 7;
  localparam int STOPNUM_W = 8;
  localparam int COUNT_W   = 8;
  localparam int SHIFT_W   = 6;
  localparam int HIST_DEPTH = 1 << KEY_W;
  localparam int STOP_IDX_W = (STOP_COUNT > 1) ? $clog2(STOP_COUNT) : 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_XPOSE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STOPS = 1'd1;

  // input event kinds
  localparam logic [KIND_W-1:0] KIND_NOTE_OFF    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_ON     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PRESSURE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_XPOSE_DOWN  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_XPOSE_UP    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STOP_TOGGLE = 3'd5;

  // result kinds
  localparam logic [OKIND_W-1:0] OUT_NOTE_OFF = 2'd0;
  localparam logic [OKIND_W-1:0] OUT_NOTE_ON  = 2'd1;
  localparam logic [OKIND_W-1:0] OUT_PRESSURE = 2'd2;

  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(TRANSPOSE_LIMIT);
  localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = -SHIFT_MAX;

  // unison stop (index 1) on after reset
  localparam logic [STOP_COUNT-1:0] STOP_EN_RESET = STOP_COUNT'(2);

  typedef struct packed {
    logic               rd_en;
    logic [KEY_W-1:0]   rd_addr;
    logic               wr_en;
    logic [KEY_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;
  } hist_req_t;

  // key offset of stop idx: (idx - 1) * 12, modulo 128
  function automatic logic [KEY_W-1:0] stop_offset(input logic [STOP_IDX_W-1:0] idx);
    int off;
    off = (int'(idx) - 1) * STOP_SPACING;
    return off[KEY_W-1:0];
  endfunction

endpackage

// ===== design/mtsl_in_if.sv =====
// Interfaces for the event input channel and the result channel.
`timescale 1ns / 1ps
interface mtsl_in_if;
  logic                            valid;
  logic                            ready;
  logic [mtsl_pkg::KIND_W-1:0]     kind;
  logic [mtsl_pkg::CHAN_W-1:0]     channel;
  logic [mtsl_pkg::KEY_W-1:0]      key;
  logic [mtsl_pkg::AMT_W-1:0]      amount;
  logic [mtsl_pkg::STOPNUM_W-1:0]  stop_number;

  modport source (output valid, kind, channel, key, amount, stop_number, input ready);
  modport sink   (input valid, kind, channel, key, amount, stop_number, output ready);
endinterface

interface mtsl_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtsl_pkg::OKIND_W-1:0]  out_kind;
  logic [mtsl_pkg::CHAN_W-1:0]   out_channel;
  logic [mtsl_pkg::KEY_W-1:0]    out_key;
  logic [mtsl_pkg::AMT_W-1:0]    out_amount;
  logic [mtsl_pkg::COUNT_W-1:0]  note_count;
  logic                          last;

  modport source (output valid, out_kind, out_channel, out_key, out_amount, note_count, last,
                  input ready);
  modport sink   (input valid, out_kind, out_channel, out_key, out_amount, note_count, last,
                  output ready);
endinterface

// ===== design/mtsl_hist.sv =====
// Key histogram memory: sync read, per-entry valid bits, write forwarding.
`timescale 1ns / 1ps
module mtsl_hist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtsl_pkg::hist_req_t           req,
  output logic [mtsl_pkg::COUNT_W-1:0]  rd_count
);

  logic [mtsl_pkg::COUNT_W-1:0] mem [mtsl_pkg::HIST_DEPTH];
  logic [mtsl_pkg::HIST_DEPTH-1:0] hvld_r;

  logic [mtsl_pkg::COUNT_W-1:0] rd_data_r;
  logic                         rd_vld_r;
  logic [mtsl_pkg::KEY_W-1:0]   rd_addr_r;
  logic                         fwd_vld_r;
  logic [mtsl_pkg::KEY_W-1:0]   fwd_addr_r;
  logic [mtsl_pkg::COUNT_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
    if (req.wr_en) begin
      fwd_addr_r <= req.wr_addr;
      fwd_data_r <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvld_r    <= '0;
      rd_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_vld_r <= hvld_r[req.rd_addr];
      end
      if (req.wr_en) begin
        hvld_r[req.wr_addr] <= 1'b1;
        fwd_vld_r           <= 1'b1;
      end
    end
  end

  // last write always wins: covers a write in the same cycle as the read
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == rd_addr_r)) begin
      rd_count = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_count = rd_data_r;
    end else begin
      rd_count = '0;
    end
  end

endmodule

// ===== design/midi_transpose_stops_layer_core.sv =====
// Top level: MIDI transpose and stops layering with a per-key note-on histogram.
`timescale 1ns / 1ps
// Usage
//   in_ch  : parsed events (kind, channel, key, amount, stop_number), valid/ready.
//   out_ch : result events, valid/ready; last marks the final result of an event.
//   cfg_*  : write port for transpose_in_chain (index 0) and stops_in_chain
//            (index 1); write only while no event is in flight.
// Each note event produces one result per enabled stop (or one when stops are
// out of the chain); pressure produces one; control events produce none.
// Pipeline: issue stage (one copy per cycle unless stalled, histogram read) -> update stage
// (read-modify-write, forwarded) -> output register. Sustained rate is one result
// per cycle while out_ch is ready, so a note occupies the issue stage until its last
// copy has issued; the next event is taken in the cycle its predecessor's last copy
// leaves that stage.
// The histogram RAM has one read and one write port; the issue stage is the limit.
// Reset: synchronous, active low. Clears shift, stop enables (unison on), chain
// bits, pipeline valids and the histogram valid bits, so all counts read zero.
// No clearing pass is needed. A stall on out_ch holds the output register and
// backs up through the pipeline to in_ch.ready.
module midi_transpose_stops_layer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  mtsl_in_if.sink                          in_ch,
  mtsl_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [mtsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SC = mtsl_pkg::STOP_COUNT;

  // configuration and control state
  logic                                  xpose_on_r;
  logic                                  stops_on_r;
  logic signed [mtsl_pkg::SHIFT_W-1:0]   shift_r;
  logic [SC-1:0]                         stop_en_r;

  // issue stage (A)
  logic                                  a_vld_r;
  logic [mtsl_pkg::OKIND_W-1:0]          a_kind_r;
  logic [mtsl_pkg::CHAN_W-1:0]           a_ch_r;
  logic [mtsl_pkg::AMT_W-1:0]            a_amt_r;
  logic [mtsl_pkg::KEY_W-1:0]            a_base_r;
  logic [SC-1:0]                         a_mask_r;
  logic                                  a_layer_r;
  logic                                  a_bump_r;
  logic                                  a_pres_r;

  // update stage (B)
  logic                                  b_vld_r;
  logic [mtsl_pkg::OKIND_W-1:0]          b_kind_r;
  logic [mtsl_pkg::CHAN_W-1:0]           b_ch_r;
  logic [mtsl_pkg::AMT_W-1:0]            b_amt_r;
  logic [mtsl_pkg::KEY_W-1:0]            b_key_r;
  logic                                  b_bump_r;
  logic                                  b_pres_r;
  logic                                  b_last_r;

  // output register
  logic                                  o_vld_r;
  logic [mtsl_pkg::OKIND_W-1:0]          o_kind_r;
  logic [mtsl_pkg::CHAN_W-1:0]           o_ch_r;
  logic [mtsl_pkg::KEY_W-1:0]            o_key_r;
  logic [mtsl_pkg::AMT_W-1:0]            o_amt_r;
  logic [mtsl_pkg::COUNT_W-1:0]          o_cnt_r;
  logic                                  o_last_r;

  logic                                  in_fire;
  logic                                  a_fire, b_fire, b_ready, o_free;
  logic [mtsl_pkg::STOP_IDX_W-1:0]       a_sel;
  logic [SC-1:0]                         a_mask_left;
  logic                                  a_last;
  logic [mtsl_pkg::KEY_W-1:0]            a_key;
  logic                                  in_is_note, in_is_pres;
  logic [SC-1:0]                         in_mask;
  logic [mtsl_pkg::KEY_W-1:0]            in_base;
  logic [mtsl_pkg::COUNT_W-1:0]          hist_count, b_count;
  mtsl_pkg::hist_req_t                   hreq;

  // handshakes
  assign o_free  = !o_vld_r || out_ch.ready;
  assign b_fire  = b_vld_r && o_free;
  assign b_ready = !b_vld_r || b_fire;
  assign a_fire  = a_vld_r && b_ready;

  // pick lowest pending stop
  always_comb begin
    a_sel = '0;
    for (int i = SC - 1; i >= 0; i--) begin
      if (a_mask_r[i]) begin
        a_sel = mtsl_pkg::STOP_IDX_W'(i);
      end
    end
  end

  assign a_mask_left = a_mask_r & ~(SC'(1) << a_sel);
  assign a_last      = (a_mask_left == '0);
  assign a_key       = a_base_r + (a_layer_r ? mtsl_pkg::stop_offset(a_sel) : '0);

  assign in_ch.ready = !a_vld_r || (a_fire && a_last);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_is_note = (in_ch.kind == mtsl_pkg::KIND_NOTE_OFF) ||
                      (in_ch.kind == mtsl_pkg::KIND_NOTE_ON);
  assign in_is_pres = (in_ch.kind == mtsl_pkg::KIND_PRESSURE);
  assign in_mask    = stops_on_r ? stop_en_r : SC'(1);
  assign in_base    = in_ch.key +
                      (xpose_on_r ? mtsl_pkg::KEY_W'(shift_r) : '0);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xpose_on_r <= 1'b0;
      stops_on_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtsl_pkg::CFG_IDX_XPOSE: xpose_on_r <= cfg_data[0];
        mtsl_pkg::CFG_IDX_STOPS: stops_on_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control events: transpose steps saturate, stop toggles ignore bad indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= '0;
      stop_en_r <= mtsl_pkg::STOP_EN_RESET;
    end else if (in_fire) begin
      if (in_ch.kind == mtsl_pkg::KIND_XPOSE_DOWN) begin
        if (shift_r > mtsl_pkg::SHIFT_MIN) shift_r <= shift_r - mtsl_pkg::SHIFT_W'(1);
      end else if (in_ch.kind == mtsl_pkg::KIND_XPOSE_UP) begin
        if (shift_r < mtsl_pkg::SHIFT_MAX) shift_r <= shift_r + mtsl_pkg::SHIFT_W'(1);
      end else if (in_ch.kind == mtsl_pkg::KIND_STOP_TOGGLE) begin
        if (in_ch.stop_number < mtsl_pkg::STOPNUM_W'(SC)) begin
          stop_en_r[in_ch.stop_number[mtsl_pkg::STOP_IDX_W-1:0]] <=
            !stop_en_r[in_ch.stop_number[mtsl_pkg::STOP_IDX_W-1:0]];
        end
      end
    end
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_fire) begin
      // notes with no stop enabled, control and unknown kinds take no slot
      a_vld_r <= (in_is_note && (in_mask != '0)) || in_is_pres;
    end else if (a_fire && a_last) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_kind_r  <= in_ch.kind[mtsl_pkg::OKIND_W-1:0];
      a_ch_r    <= in_ch.channel;
      a_amt_r   <= in_ch.amount;
      a_pres_r  <= in_is_pres;
      a_bump_r  <= (in_ch.kind == mtsl_pkg::KIND_NOTE_ON) && (in_ch.channel == '0);
      a_layer_r <= in_is_note && stops_on_r;
      a_base_r  <= in_is_pres ? '0 : in_base;
      a_mask_r  <= in_is_pres ? SC'(1) : in_mask;
    end else if (a_fire) begin
      a_mask_r  <= a_mask_left;
    end
  end

  // update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_ready) begin
      b_vld_r <= a_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_kind_r <= a_kind_r;
      b_ch_r   <= a_ch_r;
      b_amt_r  <= a_amt_r;
      b_key_r  <= a_key;
      b_bump_r <= a_bump_r;
      b_pres_r <= a_pres_r;
      b_last_r <= a_last;
    end
  end

  assign b_count = hist_count + mtsl_pkg::COUNT_W'(b_bump_r);

  always_comb begin
    hreq.rd_en   = a_fire && !a_pres_r;
    hreq.rd_addr = a_key;
    hreq.wr_en   = b_fire && b_bump_r;
    hreq.wr_addr = b_key_r;
    hreq.wr_data = b_count;
  end

  mtsl_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (hreq),
    .rd_count (hist_count)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (o_free) begin
      o_vld_r <= b_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      o_kind_r <= b_kind_r;
      o_ch_r   <= b_ch_r;
      o_key_r  <= b_key_r;
      o_amt_r  <= b_amt_r;
      o_cnt_r  <= b_pres_r ? '0 : b_count;
      o_last_r <= b_last_r;
    end
  end

  assign out_ch.valid       = o_vld_r;
  assign out_ch.out_kind    = o_kind_r;
  assign out_ch.out_channel = o_ch_r;
  assign out_ch.out_key     = o_key_r;
  assign out_ch.out_amount  = o_amt_r;
  assign out_ch.note_count  = o_cnt_r;
  assign out_ch.last        = o_last_r;

endmodule

// ===== design/mtsl_checker.sv =====
// Port-level checker for the transpose / stops layer block, bound to the top level.
`timescale 1ns / 1ps
`include "midi_transpose_stops_layer_core_defines.svh"
module mtsl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mtsl_pkg::OKIND_W-1:0]  out_kind,
  input logic [mtsl_pkg::KEY_W-1:0]    out_key,
  input logic [mtsl_pkg::COUNT_W-1:0]  note_count,
  input logic                          out_last
);

  `MTSL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `MTSL_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_key) && $stable(out_last))
  `MTSL_ASSERT(a_pressure_single, out_valid && (out_kind == mtsl_pkg::OUT_PRESSURE) |-> (out_key == '0) && (note_count == '0) && out_last)
  `MTSL_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind midi_transpose_stops_layer_core mtsl_checker u_mtsl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.out_kind),
  .out_key    (out_ch.out_key),
  .note_count (out_ch.note_count),
  .out_last   (out_ch.last)
);
